// ----- src/sine_cosine_poly_unit_top_macros.svh -----
// assertion macros for the sine/cosine unit
// used by sine_cosine_poly_unit_top, expects clk and arst_n in scope
`ifndef SINE_COSINE_POLY_UNIT_TOP_MACROS_SVH
`define SINE_COSINE_POLY_UNIT_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/scp_pkg.sv -----
// shared types, Q.56 constants and arithmetic helpers for the sine/cosine unit
// no dependencies; imported by sine_cosine_poly_unit_top
package scp_pkg;

	// internal fixed-point format: signed 64 bits, 56 fraction bits
	localparam int QW = 64;
	localparam int IFRAC = 56;
	localparam int HW = QW / 2;

	localparam int ANGLE_WIDTH_DEF = 32;
	localparam int RESULT_FRAC_BITS_DEF = 30;

	localparam logic [QW-1:0] DEC_DEN = 64'd10000000000;

	localparam logic signed [QW-1:0] K_TWO_OVER_PI = 64'sh00A2F9836E4E4415;
	localparam logic signed [QW-1:0] K_PI_OVER_TWO = 64'sh01921FB54442D184;
	localparam logic signed [QW-1:0] ONE_FIX = 64'sh0100000000000000;
	localparam logic [QW-1:0] HALF_FIX = 64'h0080000000000000;

	// sign and magnitude of a Q.56 value
	typedef struct packed {
		logic neg;
		logic [QW-1:0] mag;
	} sm_t;

	// signed sum together with its sign and magnitude
	typedef struct packed {
		logic [QW-1:0] val;
		sm_t sm;
	} add_t;

	// partial products of two magnitudes
	typedef struct packed {
		logic neg;
		logic [QW-1:0] p00;
		logic [QW-1:0] p01;
		logic [QW-1:0] p10;
		logic [QW-1:0] p11;
	} pp_t;

	// low half with carries and high half of a product
	typedef struct packed {
		logic neg;
		logic [QW+1:0] lo;
		logic [QW-1:0] hi;
	} mid_t;

	// decimal coefficient in units of 1e-10 to Q.56, rounded, elaboration only
	function automatic logic signed [QW-1:0] dec_to_fix(input logic signed [QW-1:0] num);
		logic neg;
		logic [QW-1:0] rem;
		logic [QW-1:0] res;
		neg = num[QW-1];
		rem = neg ? QW'(-num) : QW'(num);
		res = '0;
		for (int i = 0; i < IFRAC + 1; i++) begin
			rem = rem << 1;
			res = res << 1;
			if (rem >= DEC_DEN) begin
				rem = rem - DEC_DEN;
				res[0] = 1'b1;
			end
		end
		res = (res + 64'd1) >> 1;
		return neg ? -$signed(res) : $signed(res);
	endfunction

	function automatic logic [QW-1:0] fix_abs(input logic signed [QW-1:0] v);
		return v[QW-1] ? QW'(-v) : QW'(v);
	endfunction

	// polynomial coefficients
	localparam logic signed [QW-1:0] K_CC0 = dec_to_fix(-64'sd13602249);
	localparam logic signed [QW-1:0] K_CC1 = dec_to_fix(64'sd416566950);
	localparam logic signed [QW-1:0] K_CC2 = dec_to_fix(-64'sd4999990225);
	localparam logic signed [QW-1:0] K_SC0 = dec_to_fix(-64'sd1950727);
	localparam logic signed [QW-1:0] K_SC1 = dec_to_fix(64'sd83320758);
	localparam logic signed [QW-1:0] K_SC2 = dec_to_fix(-64'sd1666665247);
	localparam logic [QW-1:0] KM_CC0 = fix_abs(K_CC0);
	localparam logic [QW-1:0] KM_SC0 = fix_abs(K_SC0);

	// first multiply step: four half-width products
	function automatic pp_t mul_pp(input logic neg, input logic [QW-1:0] a,
			input logic [QW-1:0] b);
		pp_t p;
		p.neg = neg;
		p.p00 = a[HW-1:0] * b[HW-1:0];
		p.p01 = a[HW-1:0] * b[QW-1:HW];
		p.p10 = a[QW-1:HW] * b[HW-1:0];
		p.p11 = a[QW-1:HW] * b[QW-1:HW];
		return p;
	endfunction

	// second multiply step: low column sum with rounding half, high column sum
	function automatic mid_t mul_mid(input pp_t p);
		mid_t m;
		m.neg = p.neg;
		m.lo = (QW+2)'(p.p00) + (QW+2)'({p.p01[HW-1:0], {HW{1'b0}}})
			+ (QW+2)'({p.p10[HW-1:0], {HW{1'b0}}}) + (QW+2)'(HALF_FIX);
		m.hi = p.p11 + QW'(p.p01[QW-1:HW]) + QW'(p.p10[QW-1:HW]);
		return m;
	endfunction

	// third multiply step: carry into the high half, take the Q.56 magnitude
	function automatic sm_t mul_fin(input mid_t m);
		logic [QW-1:0] h;
		sm_t r;
		h = m.hi + QW'(m.lo[QW+1:QW]);
		r.neg = m.neg;
		r.mag = {1'b0, h[QW-IFRAC+IFRAC-10:0], m.lo[QW-1:IFRAC]};
		return r;
	endfunction

	// k plus a sign-magnitude term, with the sign and magnitude of the sum
	function automatic add_t add_abs(input logic [QW-1:0] k, input logic neg,
			input logic [QW-1:0] mag);
		logic [QW-1:0] sum;
		logic [QW-1:0] nsum;
		add_t r;
		sum = neg ? k - mag : k + mag;
		nsum = neg ? mag - k : (~k + 64'd1) - mag;
		r.val = sum;
		r.sm.neg = sum[QW-1];
		r.sm.mag = sum[QW-1] ? nsum : sum;
		return r;
	endfunction

	// quadrant: floor(t + 1/2) of a signed-magnitude Q.56 value
	function automatic logic signed [QW-IFRAC-1:0] quad_of(input sm_t t);
		logic [QW-1:0] tv;
		tv = t.neg ? (~t.mag + HALF_FIX + 64'd1) : (t.mag + HALF_FIX);
		return tv[QW-1:IFRAC];
	endfunction

	// select sine or cosine polynomial and its sign by quadrant offset
	function automatic logic [QW-1:0] pick_neg(input logic [1:0] off,
			input logic [QW-1:0] s, input logic [QW-1:0] c);
		logic [QW-1:0] v;
		v = off[0] ? c : s;
		return off[1] ? (~v + 64'd1) : v;
	endfunction

endpackage

// ----- src/sine_cosine_poly_unit_top.sv -----
// stages: 24 register stages, result_valid is the valid bit of the last one
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined
// 32x32 partial-product multipliers; a stalled output holds the last stage; earlier stages
// keep moving into empty slots, so items are taken until the pipeline is full
// reset: arst_n clears all stage valid bits asynchronously, data registers are not reset
`include "sine_cosine_poly_unit_top_macros.svh"

module sine_cosine_poly_unit_top #(
	parameter int ANGLE_WIDTH = scp_pkg::ANGLE_WIDTH_DEF,
	parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic signed [ANGLE_WIDTH-1:0] angle,
	input logic angle_valid,
	output logic angle_stall,
	output logic signed [RESULT_FRAC_BITS+1:0] sine,
	output logic signed [RESULT_FRAC_BITS+1:0] cosine,
	output logic result_valid,
	input logic result_stall
);
	import scp_pkg::*;

	localparam int NS = 24;
	localparam int RW = RESULT_FRAC_BITS + 2;
	localparam int A_SHIFT = IFRAC - (ANGLE_WIDTH - 4);
	localparam int SH = IFRAC - RESULT_FRAC_BITS;
	localparam logic signed [QW-1:0] RND = 64'sd1 <<< (SH - 1);
	localparam logic signed [QW-1:0] ONE_Y = 64'sd1 <<< RESULT_FRAC_BITS;
	localparam logic signed [RW-1:0] R_ONE = ONE_Y[RW-1:0];

	// Q.56 to output format: round half up, clamp to [-1, +1]
	function automatic logic [RW-1:0] to_result(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] y;
		y = (v + RND) >>> SH;
		if (y > ONE_Y) begin
			y = ONE_Y;
		end else if (y < -ONE_Y) begin
			y = -ONE_Y;
		end
		return y[RW-1:0];
	endfunction

	logic [NS:1] v_q;
	logic [NS:1] en;
	logic signed [QW-1:0] a56_w;
	add_t a56_abs_w;
	sm_t r2_w;
	add_t cp_w, sp_w;

	// reduction stages
	logic [QW-1:0] a56_s1, a56_s2, a56_s3, a56_s4, a56_s5, a56_s6;
	sm_t asm_s1;
	pp_t tpp_s2;
	mid_t tmd_s3;
	sm_t tsm_s4;
	logic signed [QW-IFRAC-1:0] q_s5;
	logic [QW-1:0] qp_s6;
	add_t r_s7, r_s8, r_s9, r_s10;

	// quadrant bits travelling to the select stage
	logic [1:0] qm_s6, qm_s7, qm_s8, qm_s9, qm_s10, qm_s11, qm_s12, qm_s13, qm_s14;
	logic [1:0] qm_s15, qm_s16, qm_s17, qm_s18, qm_s19, qm_s20, qm_s21, qm_s22;

	// powers of r
	pp_t r2pp_s8;
	mid_t r2md_s9;
	logic [QW-1:0] r2_s10, r2_s11, r2_s12, r2_s13, r2_s14, r2_s15, r2_s16, r2_s17, r2_s18;
	pp_t r3pp_s11;
	mid_t r3md_s12;
	sm_t r3_s13, r3_s14, r3_s15, r3_s16, r3_s17, r3_s18;
	logic [QW-1:0] rv_s11, rv_s12, rv_s13, rv_s14, rv_s15, rv_s16, rv_s17, rv_s18;
	logic [QW-1:0] rv_s19, rv_s20, rv_s21;

	// horner steps
	pp_t c1pp_s11, s1pp_s11, c2pp_s15, s2pp_s15, c3pp_s19, s3pp_s19;
	mid_t c1md_s12, s1md_s12, c2md_s16, s2md_s16, c3md_s20, s3md_s20;
	sm_t cpm1_s13, spm1_s13, cpm2_s17, spm2_s17, cpm3_s21, spm3_s21;
	add_t c1_s14, s1_s14, c2_s18, s2_s18;
	logic [QW-1:0] cp_s22, sp_s22, sv_s23, cv_s23;
	logic signed [RW-1:0] sine_s24, cosine_s24;

	// angle into Q.56
	assign a56_w = $signed({{(QW-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle}) <<< A_SHIFT;

	// helper results taken apart in the stage registers
	assign a56_abs_w = add_abs(a56_w, 1'b0, '0);
	assign r2_w = mul_fin(r2md_s9);
	assign cp_w = add_abs(ONE_FIX, cpm3_s21.neg, cpm3_s21.mag);
	assign sp_w = add_abs(rv_s21, spm3_s21.neg, spm3_s21.mag);

	// stage enables: a stage loads when empty or when its item moves on
	always_comb begin
		en[NS] = !v_q[NS] || !result_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign angle_stall = !en[1];
	assign result_valid = v_q[NS];
	assign sine = sine_s24;
	assign cosine = cosine_s24;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= angle_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// data path
	always_ff @(posedge clk) begin
		// angle and its magnitude
		if (en[1]) begin
			a56_s1 <= a56_w;
			asm_s1 <= a56_abs_w.sm;
		end
		// t = angle * 2/pi
		if (en[2]) begin
			tpp_s2 <= mul_pp(asm_s1.neg, asm_s1.mag, K_TWO_OVER_PI);
			a56_s2 <= a56_s1;
		end
		if (en[3]) begin
			tmd_s3 <= mul_mid(tpp_s2);
			a56_s3 <= a56_s2;
		end
		if (en[4]) begin
			tsm_s4 <= mul_fin(tmd_s3);
			a56_s4 <= a56_s3;
		end
		// quadrant
		if (en[5]) begin
			q_s5 <= quad_of(tsm_s4);
			a56_s5 <= a56_s4;
		end
		if (en[6]) begin
			qp_s6 <= q_s5 * K_PI_OVER_TWO;
			qm_s6 <= q_s5[1:0];
			a56_s6 <= a56_s5;
		end
		// reduced angle r
		if (en[7]) begin
			r_s7 <= add_abs(a56_s6, 1'b1, qp_s6);
			qm_s7 <= qm_s6;
		end
		// r^2
		if (en[8]) begin
			r2pp_s8 <= mul_pp(1'b0, r_s7.sm.mag, r_s7.sm.mag);
			r_s8 <= r_s7;
			qm_s8 <= qm_s7;
		end
		if (en[9]) begin
			r2md_s9 <= mul_mid(r2pp_s8);
			r_s9 <= r_s8;
			qm_s9 <= qm_s8;
		end
		if (en[10]) begin
			r2_s10 <= r2_w.mag;
			r_s10 <= r_s9;
			qm_s10 <= qm_s9;
		end
		// r^3 and first horner products
		if (en[11]) begin
			r3pp_s11 <= mul_pp(r_s10.sm.neg, r2_s10, r_s10.sm.mag);
			c1pp_s11 <= mul_pp(K_CC0[QW-1], KM_CC0, r2_s10);
			s1pp_s11 <= mul_pp(K_SC0[QW-1], KM_SC0, r2_s10);
			r2_s11 <= r2_s10;
			rv_s11 <= r_s10.val;
			qm_s11 <= qm_s10;
		end
		if (en[12]) begin
			r3md_s12 <= mul_mid(r3pp_s11);
			c1md_s12 <= mul_mid(c1pp_s11);
			s1md_s12 <= mul_mid(s1pp_s11);
			r2_s12 <= r2_s11;
			rv_s12 <= rv_s11;
			qm_s12 <= qm_s11;
		end
		if (en[13]) begin
			r3_s13 <= mul_fin(r3md_s12);
			cpm1_s13 <= mul_fin(c1md_s12);
			spm1_s13 <= mul_fin(s1md_s12);
			r2_s13 <= r2_s12;
			rv_s13 <= rv_s12;
			qm_s13 <= qm_s12;
		end
		if (en[14]) begin
			c1_s14 <= add_abs(K_CC1, cpm1_s13.neg, cpm1_s13.mag);
			s1_s14 <= add_abs(K_SC1, spm1_s13.neg, spm1_s13.mag);
			r3_s14 <= r3_s13;
			r2_s14 <= r2_s13;
			rv_s14 <= rv_s13;
			qm_s14 <= qm_s13;
		end
		// second horner step
		if (en[15]) begin
			c2pp_s15 <= mul_pp(c1_s14.sm.neg, c1_s14.sm.mag, r2_s14);
			s2pp_s15 <= mul_pp(s1_s14.sm.neg, s1_s14.sm.mag, r2_s14);
			r3_s15 <= r3_s14;
			r2_s15 <= r2_s14;
			rv_s15 <= rv_s14;
			qm_s15 <= qm_s14;
		end
		if (en[16]) begin
			c2md_s16 <= mul_mid(c2pp_s15);
			s2md_s16 <= mul_mid(s2pp_s15);
			r3_s16 <= r3_s15;
			r2_s16 <= r2_s15;
			rv_s16 <= rv_s15;
			qm_s16 <= qm_s15;
		end
		if (en[17]) begin
			cpm2_s17 <= mul_fin(c2md_s16);
			spm2_s17 <= mul_fin(s2md_s16);
			r3_s17 <= r3_s16;
			r2_s17 <= r2_s16;
			rv_s17 <= rv_s16;
			qm_s17 <= qm_s16;
		end
		if (en[18]) begin
			c2_s18 <= add_abs(K_CC2, cpm2_s17.neg, cpm2_s17.mag);
			s2_s18 <= add_abs(K_SC2, spm2_s17.neg, spm2_s17.mag);
			r3_s18 <= r3_s17;
			r2_s18 <= r2_s17;
			rv_s18 <= rv_s17;
			qm_s18 <= qm_s17;
		end
		// last horner step: cosine by r^2, sine by r^3
		if (en[19]) begin
			c3pp_s19 <= mul_pp(c2_s18.sm.neg, c2_s18.sm.mag, r2_s18);
			s3pp_s19 <= mul_pp(s2_s18.sm.neg ^ r3_s18.neg, s2_s18.sm.mag, r3_s18.mag);
			rv_s19 <= rv_s18;
			qm_s19 <= qm_s18;
		end
		if (en[20]) begin
			c3md_s20 <= mul_mid(c3pp_s19);
			s3md_s20 <= mul_mid(s3pp_s19);
			rv_s20 <= rv_s19;
			qm_s20 <= qm_s19;
		end
		if (en[21]) begin
			cpm3_s21 <= mul_fin(c3md_s20);
			spm3_s21 <= mul_fin(s3md_s20);
			rv_s21 <= rv_s20;
			qm_s21 <= qm_s20;
		end
		if (en[22]) begin
			cp_s22 <= cp_w.val;
			sp_s22 <= sp_w.val;
			qm_s22 <= qm_s21;
		end
		// quadrant select
		if (en[23]) begin
			sv_s23 <= pick_neg(qm_s22, sp_s22, cp_s22);
			cv_s23 <= pick_neg(qm_s22 + 2'd1, sp_s22, cp_s22);
		end
		// output conversion
		if (en[24]) begin
			sine_s24 <= to_result(sv_s23);
			cosine_s24 <= to_result(cv_s23);
		end
	end

	// checks
	`SCP_ASSERT_NXT(a_accept_fills, angle_valid && !angle_stall, v_q[1], "item lost at stage one")
	`SCP_ASSERT_IMP(a_full_stalls, (&v_q) && result_stall, angle_stall, "item taken while full")
	`SCP_ASSERT_IMP(a_sine_range, result_valid, (sine <= R_ONE) && (sine >= -R_ONE), "sine beyond one")
	`SCP_ASSERT_IMP(a_cos_range, result_valid, (cosine <= R_ONE) && (cosine >= -R_ONE), "cosine beyond one")

endmodule
